// ===== rtl/tsc_pkg.sv =====
// shared types and constants for the tilt sensor conditioner
package tsc_pkg;

  // input sample as it arrives from the sensor side
  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
    logic               waiting_mode;
    logic               settled;
  } tsc_in_t;

  // conditioned result item
  typedef struct packed {
    logic signed [15:0] x_axis;
    logic signed [15:0] y_axis;
    logic               tilt_active;
    logic               x_changed;
    logic               y_changed;
  } tsc_out_t;

  // configuration register indexes
  localparam logic [1:0] REG_MOUNT_ORIENTATION = 2'd0;
  localparam logic [1:0] REG_DEAD_ZONE         = 2'd1;
  localparam logic [1:0] REG_TILT_THRESHOLD    = 2'd2;

  localparam int CFG_DATA_W = 15;

  // mount orientation fields
  localparam int ORIENT_Z_BIT = 3;

  localparam logic [2:0] ROT_IDENTITY = 3'd0;
  localparam logic [2:0] ROT_CW90     = 3'd1;
  localparam logic [2:0] ROT_180      = 3'd2;
  localparam logic [2:0] ROT_CCW90    = 3'd3;
  localparam logic [2:0] ROT_FLIP_X   = 3'd4;
  localparam logic [2:0] ROT_ANTIDIAG = 3'd5;
  localparam logic [2:0] ROT_FLIP_Y   = 3'd6;
  localparam logic [2:0] ROT_SWAP     = 3'd7;

  // offset divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_PREP,
    DIV_MUL,
    DIV_FIX
  } tsc_div_state_t;

endpackage

// ===== rtl/tsc_offset_div.sv =====
// floor average of the calibration sums by reciprocal multiplication
module tsc_offset_div #(
  parameter int CAL_SAMPLES = 50,
  parameter int SUM_W       = 22
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] x_sum,
  input  logic signed [SUM_W-1:0] y_sum,
  output logic                    busy,
  output logic signed [15:0]      x_offset,
  output logic signed [15:0]      y_offset
);
  import tsc_pkg::*;

  localparam int SHIFT = SUM_W + 7;
  localparam int MW    = SHIFT + 1;
  localparam int PW    = SUM_W + MW;
  localparam longint unsigned RECIP_L = (64'd1 << SHIFT) / CAL_SAMPLES;
  localparam logic [MW-1:0]    RECIP   = MW'(RECIP_L);
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(CAL_SAMPLES);

  tsc_div_state_t state;
  tsc_div_state_t state_next;

  logic             x_neg;
  logic             y_neg;
  logic [SUM_W-1:0] x_mag;
  logic [SUM_W-1:0] y_mag;
  logic [PW-1:0]    x_prod;
  logic [PW-1:0]    y_prod;

  logic [SUM_W-1:0] x_flip;
  logic [SUM_W-1:0] y_flip;
  logic [SUM_W-1:0] x_mag_next;
  logic [SUM_W-1:0] y_mag_next;
  logic [SUM_W-1:0] x_q0;
  logic [SUM_W-1:0] y_q0;
  logic [SUM_W-1:0] x_back;
  logic [SUM_W-1:0] y_back;
  logic [SUM_W-1:0] x_rem;
  logic [SUM_W-1:0] y_rem;
  logic [SUM_W-1:0] x_q;
  logic [SUM_W-1:0] y_q;
  logic [SUM_W-1:0] x_off_next;
  logic [SUM_W-1:0] y_off_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_PREP;
      DIV_PREP: state_next = DIV_MUL;
      DIV_MUL:  state_next = DIV_FIX;
      DIV_FIX:  state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    case (state)
      DIV_IDLE: busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // negative sums divide as ceil of the magnitude, then negate
  always_comb begin
    x_flip     = SUM_W'(-x_sum);
    y_flip     = SUM_W'(-y_sum);
    x_mag_next = x_sum[SUM_W-1] ? x_flip + DIVISOR - SUM_W'(1) : SUM_W'(x_sum);
    y_mag_next = y_sum[SUM_W-1] ? y_flip + DIVISOR - SUM_W'(1) : SUM_W'(y_sum);
  end

  // quotient estimate is exact or one low; one compare fixes it
  always_comb begin
    x_q0       = SUM_W'(x_prod >> SHIFT);
    y_q0       = SUM_W'(y_prod >> SHIFT);
    x_back     = SUM_W'(x_q0 * DIVISOR);
    y_back     = SUM_W'(y_q0 * DIVISOR);
    x_rem      = x_mag - x_back;
    y_rem      = y_mag - y_back;
    x_q        = (x_rem >= DIVISOR) ? x_q0 + SUM_W'(1) : x_q0;
    y_q        = (y_rem >= DIVISOR) ? y_q0 + SUM_W'(1) : y_q0;
    x_off_next = x_neg ? SUM_W'(-x_q) : x_q;
    y_off_next = y_neg ? SUM_W'(-y_q) : y_q;
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (state == DIV_PREP) begin
      x_neg <= x_sum[SUM_W-1];
      y_neg <= y_sum[SUM_W-1];
      x_mag <= x_mag_next;
      y_mag <= y_mag_next;
    end
    if (state == DIV_MUL) begin
      x_prod <= PW'(x_mag) * PW'(RECIP);
      y_prod <= PW'(y_mag) * PW'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      y_offset <= '0;
    end else if (state == DIV_FIX) begin
      x_offset <= x_off_next[15:0];
      y_offset <= y_off_next[15:0];
    end
  end

endmodule

// ===== rtl/tilt_sensor_conditioner_unit.sv =====
// tilt sensor conditioner top level: calibration, offset removal, rotation, tilt flag
// latency: a sample passes the stage a register and then the result register before its result is presented
// throughput: one sample per cycle unless result_ready stalls the result path; after the
//   last calibration sample, sample_ready stays low while the divider runs its PREP, MUL and FIX states
// reset: synchronous, active high; clears config to defaults and starts a calibration
module tilt_sensor_conditioner_unit #(
  parameter int CAL_SAMPLES  = 50,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  tsc_pkg::tsc_in_t               sample_data,
  output logic                           result_valid,
  input  logic                           result_ready,
  output tsc_pkg::tsc_out_t              result_data,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsc_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam int CW    = (SAMPLE_WIDTH > 17) ? SAMPLE_WIDTH : 17;
  localparam logic signed [CW-1:0] SAT_MAX = CW'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic [CNT_W-1:0]     CAL_LAST = CNT_W'(CAL_SAMPLES);

  function automatic logic signed [CW-1:0] mag(input logic signed [CW-1:0] v);
    mag = v[CW-1] ? -v : v;
  endfunction

  // configuration registers
  logic [3:0]  mount_orientation;
  logic [14:0] dead_zone;
  logic [14:0] tilt_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_orientation <= '0;
      dead_zone         <= '0;
      tilt_threshold    <= 15'h7fff;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOUNT_ORIENTATION: mount_orientation <= cfg_data[3:0];
        REG_DEAD_ZONE:         dead_zone         <= cfg_data[14:0];
        REG_TILT_THRESHOLD:    tilt_threshold    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic sample_xfer;
  logic div_busy;
  logic a_valid;
  logic a_adv;

  assign sample_xfer  = sample_valid && sample_ready;
  assign a_adv        = a_valid && (!result_valid || result_ready);
  assign sample_ready = !div_busy && (!a_valid || a_adv);

  // calibration control
  logic                    calibrating;
  logic                    recentered;
  logic [CNT_W-1:0]        cal_count;
  logic signed [SUM_W-1:0] x_sum;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [15:0]      x_offset;
  logic signed [15:0]      y_offset;

  logic signed [15:0]      hx;
  logic signed [15:0]      hy;
  logic                    start_cal;
  logic                    cal_now;
  logic [CNT_W-1:0]        cnt_inc;
  logic signed [SUM_W-1:0] x_sum_next;
  logic signed [SUM_W-1:0] y_sum_next;
  logic                    cal_done;

  always_comb begin
    hx         = mount_orientation[ORIENT_Z_BIT] ? sample_data.sample_z : sample_data.sample_x;
    hy         = sample_data.sample_y;
    start_cal  = sample_data.waiting_mode && !recentered;
    cal_now    = calibrating || start_cal;
    cnt_inc    = (start_cal ? '0 : cal_count) + CNT_W'(1);
    x_sum_next = (start_cal ? '0 : x_sum) + SUM_W'(hx);
    y_sum_next = (start_cal ? '0 : y_sum) + SUM_W'(hy);
    cal_done   = sample_xfer && cal_now && (cnt_inc == CAL_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating <= 1'b1;
      recentered  <= 1'b0;
      cal_count   <= '0;
      x_sum       <= '0;
      y_sum       <= '0;
    end else if (sample_xfer) begin
      recentered <= sample_data.waiting_mode;
      if (cal_now) begin
        // final sums stay put for the divider
        x_sum <= x_sum_next;
        y_sum <= y_sum_next;
        if (cnt_inc == CAL_LAST) begin
          calibrating <= 1'b0;
          cal_count   <= '0;
        end else begin
          calibrating <= 1'b1;
          cal_count   <= cnt_inc;
        end
      end
    end
  end

  tsc_offset_div #(
    .CAL_SAMPLES(CAL_SAMPLES),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cal_done),
    .x_sum   (x_sum),
    .y_sum   (y_sum),
    .busy    (div_busy),
    .x_offset(x_offset),
    .y_offset(y_offset)
  );

  // stage a: offset removal and saturation
  logic signed [CW-1:0] diff_x;
  logic signed [CW-1:0] diff_y;
  logic signed [CW-1:0] sat_x;
  logic signed [CW-1:0] sat_y;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic                 a_settled;

  always_comb begin
    diff_x = CW'(hx) - CW'(x_offset);
    diff_y = CW'(hy) - CW'(y_offset);
    if (diff_x > SAT_MAX)       sat_x = SAT_MAX;
    else if (diff_x < -SAT_MAX) sat_x = -SAT_MAX;
    else                        sat_x = diff_x;
    if (diff_y > SAT_MAX)       sat_y = SAT_MAX;
    else if (diff_y < -SAT_MAX) sat_y = -SAT_MAX;
    else                        sat_y = diff_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (sample_xfer && !cal_now) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_xfer && !cal_now) begin
      a_x       <= sat_x;
      a_y       <= sat_y;
      a_settled <= sample_data.settled;
    end
  end

  // stage b: dead zone, rotation, tilt hysteresis, change detect
  logic signed [CW-1:0] dz;
  logic signed [CW-1:0] th;
  logic signed [CW-1:0] zx;
  logic signed [CW-1:0] zy;
  logic signed [CW-1:0] rx;
  logic signed [CW-1:0] ry;
  logic                 over;
  logic                 under;
  logic                 tilt_state;
  logic                 tilt_next;
  logic signed [CW-1:0] prior_x;
  logic signed [CW-1:0] prior_y;

  always_comb begin
    dz = CW'(dead_zone);
    th = CW'(tilt_threshold);
    zx = (mag(a_x) < dz || !a_settled) ? '0 : a_x;
    zy = (mag(a_y) < dz || !a_settled) ? '0 : a_y;
    case (mount_orientation[2:0])
      ROT_IDENTITY: begin rx = zx;  ry = zy;  end
      ROT_CW90:     begin rx = -zy; ry = zx;  end
      ROT_180:      begin rx = -zx; ry = -zy; end
      ROT_CCW90:    begin rx = zy;  ry = -zx; end
      ROT_FLIP_X:   begin rx = -zx; ry = zy;  end
      ROT_ANTIDIAG: begin rx = -zy; ry = -zx; end
      ROT_FLIP_Y:   begin rx = zx;  ry = -zy; end
      ROT_SWAP:     begin rx = zy;  ry = zx;  end
      default:      begin rx = zx;  ry = zy;  end
    endcase
    over  = (mag(rx) > th) || (mag(ry) > th);
    under = (mag(rx) < th) && (mag(ry) < th);
    if (!tilt_state && over)     tilt_next = 1'b1;
    else if (tilt_state && under) tilt_next = 1'b0;
    else                         tilt_next = tilt_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      tilt_state   <= 1'b0;
      prior_x      <= '0;
      prior_y      <= '0;
    end else if (a_adv) begin
      result_valid <= 1'b1;
      tilt_state   <= tilt_next;
      prior_x      <= rx;
      prior_y      <= ry;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (a_adv) begin
      result_data.x_axis      <= rx[15:0];
      result_data.y_axis      <= ry[15:0];
      result_data.tilt_active <= tilt_next;
      result_data.x_changed   <= (rx != prior_x);
      result_data.y_changed   <= (ry != prior_y);
    end
  end

endmodule

// ===== rtl/tsc_checker.sv =====
// port-level checks for the tilt sensor conditioner, bound to the top level
module tsc_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_ready,
  input tsc_pkg::tsc_in_t               sample_data,
  input logic                           result_valid,
  input logic                           result_ready,
  input tsc_pkg::tsc_out_t              result_data,
  input logic                           cfg_write,
  input logic [1:0]                     cfg_index,
  input logic [tsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsc_pkg::*;

  localparam logic NARROW = (SAMPLE_WIDTH <= 16);

  // last transferred axis values, zero after reset
  logic signed [15:0] seen_x;
  logic signed [15:0] seen_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_x <= '0;
      seen_y <= '0;
    end else if (result_valid && result_ready) begin
      seen_x <= result_data.x_axis;
      seen_y <= result_data.y_axis;
    end
  end

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // reset restarts calibration, so nothing is pending right after it
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // saturation is symmetric, the most negative code never appears
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && NARROW |->
      result_data.x_axis != 16'sh8000 && result_data.y_axis != 16'sh8000)
    else $error("axis outside saturation range");

  // changed flags follow the previous transferred result
  a_changed: assert property (@(posedge clk) disable iff (rst)
    result_valid && NARROW |->
      result_data.x_changed == (result_data.x_axis != seen_x) &&
      result_data.y_changed == (result_data.y_axis != seen_y))
    else $error("changed flag disagrees with previous result");

  // sample and config ports are part of the port view but not checked here
  logic unused_ok;
  assign unused_ok = sample_valid ^ sample_ready ^ (^sample_data) ^ cfg_write ^
                     (^cfg_index) ^ (^cfg_data);

endmodule

bind tilt_sensor_conditioner_unit tsc_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_tsc_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_ready(sample_ready),
  .sample_data (sample_data),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result_data (result_data),
  .cfg_write   (cfg_write),
  .cfg_index   (cfg_index),
  .cfg_data    (cfg_data)
);
